// File: rtl/core/ucs2_compression_encoder_top_assert.svh
// Assertion macros used by the encoder RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef UCS2_COMPRESSION_ENCODER_TOP_ASSERT_SVH
`define UCS2_COMPRESSION_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UCS2CE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("encoder assertion failed");

// Next-cycle implication, checked outside reset.
`define UCS2CE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("encoder assertion failed");

`endif

// File: rtl/core/ucs2ce_pkg.sv
// Shared types and constants of the UCS-2 compression encoder.
// No dependencies.
package ucs2ce_pkg;

  // Buffer limit on code units per string.
  localparam int MAX_UNITS     = 4096;
  localparam int UNIT_W        = $clog2(MAX_UNITS + 1);
  // Worst case bytes: header plus switch, low and high byte per unit.
  localparam int BC_W          = $clog2(3 * MAX_UNITS + 3);
  localparam int LEN_W         = 14;
  localparam int MIN_SRC_BYTES = 4;
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);
  localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] HDR0_BYTE   = 8'hFF;
  localparam logic [7:0] HDR1_BYTE   = 8'hFE;
  localparam logic [7:0] SWITCH_BYTE = 8'h00;

  // Bit positions of the byte plan, in sending order.
  localparam int MB_HDR0 = 0;
  localparam int MB_HDR1 = 1;
  localparam int MB_SW   = 2;
  localparam int MB_LO   = 3;
  localparam int MB_HI   = 4;
  localparam int MB_N    = 5;

  typedef logic [MB_N-1:0] mask_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } unit_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             run_end;
    logic             string_end;
    logic             compressed_ok;
    logic [LEN_W-1:0] compressed_length;
  } result_t;

  // Command from the front to the back: which bytes to send for one word.
  typedef struct packed {
    mask_t           mask;
    logic [7:0]      lo;
    logic [7:0]      hi;
    logic            last;
    logic            ok;
    logic [BC_W-1:0] base;
  } cmd_t;

endpackage

// File: rtl/core/ucs2ce_front.sv
// Front of the encoder: accepts code units, tracks string state, plans bytes.
// Depends on ucs2ce_pkg.
module ucs2ce_front import ucs2ce_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  unit_valid,
  output logic  unit_stall,
  input  unit_t unit,
  input  logic  q_full,
  output logic  push,
  output cmd_t  cmd
);

  logic              compressed_mode, compressed_mode_next;
  logic              failed_flag, failed_flag_next;
  logic              header_sent;
  logic [BC_W-1:0]   byte_count, byte_count_next;
  logic [UNIT_W-1:0] unit_count, unit_count_next;

  logic       accept;
  logic       take, active, need_sw, lo_zero, em_lo, em_hi;
  logic [7:0] lo, hi;
  logic [2:0] nbytes;
  logic [UNIT_W:0] units_x2;
  mask_t      mask;

  assign unit_stall = q_full;
  assign accept     = unit_valid && !q_full;
  assign lo         = unit.code_unit[7:0];
  assign hi         = unit.code_unit[15:8];

  // Classify the word against the current mode and failure state.
  always_comb begin
    take    = unit_count < UNIT_W'(MAX_UNITS);
    active  = take && !failed_flag;
    need_sw = active && ((hi != 8'h00) == compressed_mode);
    compressed_mode_next = need_sw ? !compressed_mode : compressed_mode;
    lo_zero = (lo == 8'h00);
    em_lo   = active && !lo_zero;
    em_hi   = em_lo && !compressed_mode_next;
    failed_flag_next = failed_flag || (active && lo_zero);

    mask          = '0;
    mask[MB_HDR0] = take && !header_sent;
    mask[MB_HDR1] = take && !header_sent;
    mask[MB_SW]   = need_sw;
    mask[MB_LO]   = em_lo;
    mask[MB_HI]   = em_hi;

    nbytes = 3'(mask[MB_HDR0]) + 3'(mask[MB_HDR1]) + 3'(mask[MB_SW])
           + 3'(mask[MB_LO]) + 3'(mask[MB_HI]);
    unit_count_next = unit_count + UNIT_W'(take);
    byte_count_next = byte_count + BC_W'(nbytes);
    units_x2        = {unit_count_next, 1'b0};

    cmd.mask = mask;
    cmd.lo   = lo;
    cmd.hi   = hi;
    cmd.last = unit.last_unit;
    cmd.base = byte_count;
    cmd.ok   = !failed_flag_next
               && (units_x2 > (UNIT_W + 1)'(MIN_SRC_BYTES))
               && (byte_count_next < BC_W'(units_x2));
  end

  // Words with nothing to send and no string end leave no command.
  assign push = accept && ((mask != '0) || unit.last_unit);

  // String state; the final word returns everything to the start.
  always_ff @(posedge clk) begin
    if (rst) begin
      compressed_mode <= 1'b1;
      failed_flag     <= 1'b0;
      header_sent     <= 1'b0;
      byte_count      <= '0;
      unit_count      <= '0;
    end else if (accept) begin
      if (unit.last_unit) begin
        compressed_mode <= 1'b1;
        failed_flag     <= 1'b0;
        header_sent     <= 1'b0;
        byte_count      <= '0;
        unit_count      <= '0;
      end else begin
        compressed_mode <= compressed_mode_next;
        failed_flag     <= failed_flag_next;
        header_sent     <= header_sent || take;
        byte_count      <= byte_count_next;
        unit_count      <= unit_count_next;
      end
    end
  end

endmodule

// File: rtl/core/ucs2ce_fifo.sv
// Short command queue between the encoder front and back.
// Depends on ucs2ce_pkg.
module ucs2ce_fifo import ucs2ce_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_data
);

  cmd_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = entries[rd_ptr];

  // Pointer wrap for any depth.
  function automatic logic [Q_PTR_W-1:0] bump(input logic [Q_PTR_W-1:0] p);
    if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
      return '0;
    end
    return p + Q_PTR_W'(1);
  endfunction

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/core/ucs2ce_back.sv
// Encoder back: expands commands to result words, one per cycle unless stalled.
// Depends on ucs2ce_pkg and ucs2_compression_encoder_top_assert.svh.
`include "ucs2_compression_encoder_top_assert.svh"
module ucs2ce_back import ucs2ce_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  cmd_t    q_data,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic            wvalid;
  cmd_t            wcmd;
  mask_t           wmask, rem, sel;
  logic [BC_W-1:0] wlen, len_inc;
  logic            out_load, done;
  result_t         res;

  // Pick the next byte of the plan and build its result word.
  always_comb begin
    sel          = '0;
    res.out_byte = 8'h00;
    if (wmask[MB_HDR0]) begin
      sel[MB_HDR0] = 1'b1;
      res.out_byte = HDR0_BYTE;
    end else if (wmask[MB_HDR1]) begin
      sel[MB_HDR1] = 1'b1;
      res.out_byte = HDR1_BYTE;
    end else if (wmask[MB_SW]) begin
      sel[MB_SW]   = 1'b1;
      res.out_byte = SWITCH_BYTE;
    end else if (wmask[MB_LO]) begin
      sel[MB_LO]   = 1'b1;
      res.out_byte = wcmd.lo;
    end else if (wmask[MB_HI]) begin
      sel[MB_HI]   = 1'b1;
      res.out_byte = wcmd.hi;
    end
    rem     = wmask & ~sel;
    len_inc = wlen + BC_W'(1);
    // A command with no bytes is a status-only word at the string end.
    done               = (rem == '0);
    res.byte_valid     = (wmask != '0);
    res.run_end        = done;
    res.string_end     = done && wcmd.last;
    res.compressed_ok  = done && wcmd.last && wcmd.ok;
    res.compressed_length = res.byte_valid ? LEN_W'(len_inc) : LEN_W'(wlen);
  end

  assign out_load = wvalid && (!result_valid || !result_stall);
  assign pop      = q_valid && (!wvalid || (out_load && done));

  // Working command register.
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= 1'b0;
    end else if (pop) begin
      wvalid <= 1'b1;
    end else if (out_load && done) begin
      wvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      wcmd  <= q_data;
      wmask <= q_data.mask;
      wlen  <= q_data.base;
    end else if (out_load) begin
      wmask <= rem;
      wlen  <= len_inc;
    end
  end

  // Output register parts the back from the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= res;
    end
  end

  // A status-only word closes both the run and the string.
  `UCS2CE_ASSERT_NOW(a_status_ends, out_load && !res.byte_valid, res.run_end && res.string_end)
  // The keep flag only shows on the string's final word.
  `UCS2CE_ASSERT_NOW(a_ok_at_end, out_load && res.compressed_ok, res.string_end && res.run_end)
  // A pop always fills the working register for the next cycle.
  `UCS2CE_ASSERT_NEXT(a_pop_fills, pop, wvalid)

endmodule

// File: rtl/core/ucs2_compression_encoder_top.sv
// Top level of the UCS-2 compression encoder.
// Depends on ucs2ce_pkg, ucs2ce_front, ucs2ce_fifo and ucs2ce_back.

// The encoder takes one UCS-2 code unit word per cycle while its two-entry
// command queue has room, and sends one result word per cycle while the
// consumer does not stall. A unit that causes k results (one to five: header,
// mode switch, low and high byte, or a single status word at the end of a
// string) holds the back until all k are sent, one at a time through the
// single result port of the back. Units that cause no result leave no
// command in the queue. The result register holds a finished word steady
// while the consumer stalls; the back waits with it, and the input stalls
// once the command queue is full.
module ucs2_compression_encoder_top import ucs2ce_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    unit_valid,
  output logic    unit_stall,
  input  unit_t   unit,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic push, full, pop, q_valid;
  cmd_t push_data, q_data;

  // Front: classification and string state.
  ucs2ce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit       (unit),
    .q_full     (full),
    .push       (push),
    .cmd        (push_data)
  );

  // Queue between front and back.
  ucs2ce_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // Back: byte expansion and result register.
  ucs2ce_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
